// ===== sv/two_way_lru_tag_store_defines.svh =====
// assertion macros used by the checker file
`ifndef TWO_WAY_LRU_TAG_STORE_DEFINES_SVH
`define TWO_WAY_LRU_TAG_STORE_DEFINES_SVH

// same-cycle implication, quiet while in reset
`define TLS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while in reset
`define TLS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// what must hold in the cycle after a reset cycle
`define TLS_ASSERT_AFTER_RST(label, cons, msg) \
  label: assert property (@(posedge clk) !rst_n |=> (cons)) else $error(msg);

`endif

// ===== sv/tls_pkg.sv =====
package tls_pkg;

  localparam int ADDR_W = 64;

  // set index fold: page number split into bytes, each times its residue
  localparam int DIGITS  = 8;
  localparam int PROD_W  = 24;
  localparam int Y_W     = 27;
  localparam int FOLD_K  = 27;
  localparam int RECIP_W = 28;
  localparam int MUL_W   = Y_W + RECIP_W;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_MISS = 1'b1;

  // one set: both ways plus the replacement bit
  // lru set means way 0 is the least recent one
  typedef struct packed {
    logic              valid0;
    logic              valid1;
    logic              lru;
    logic [ADDR_W-1:0] tag0;
    logic [ADDR_W-1:0] tag1;
  } row_t;

  typedef struct packed {
    logic       status;
    logic       way_used;
    logic [7:0] set_number;
    logic [8:0] page_slot;
  } res_t;

  typedef struct packed {
    logic clearing;
    logic res_valid;
    logic take_ok;
  } ta_ctl_t;

endpackage

// ===== sv/tls_set_index.sv =====
module tls_set_index #(
  parameter int SETS       = 256,
  parameter int PAGE_SHIFT = 12,
  parameter int SW         = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_take,
  input  logic                      in_op,
  input  logic [tls_pkg::ADDR_W-1:0] in_addr,
  input  logic                      down_free,
  output logic                      up_free,
  output logic                      e_valid,
  output logic                      e_op,
  output logic [tls_pkg::ADDR_W-1:0] e_addr,
  output logic [SW-1:0]             e_set
);

  // residues of 256**i modulo the set count
  localparam int unsigned R0 = 1 % SETS;
  localparam int unsigned R1 = (R0 * 256) % SETS;
  localparam int unsigned R2 = (R1 * 256) % SETS;
  localparam int unsigned R3 = (R2 * 256) % SETS;
  localparam int unsigned R4 = (R3 * 256) % SETS;
  localparam int unsigned R5 = (R4 * 256) % SETS;
  localparam int unsigned R6 = (R5 * 256) % SETS;
  localparam int unsigned R7 = (R6 * 256) % SETS;

  localparam logic [tls_pkg::PROD_W-1:0] RES [tls_pkg::DIGITS] = '{
    tls_pkg::PROD_W'(R0), tls_pkg::PROD_W'(R1), tls_pkg::PROD_W'(R2),
    tls_pkg::PROD_W'(R3), tls_pkg::PROD_W'(R4), tls_pkg::PROD_W'(R5),
    tls_pkg::PROD_W'(R6), tls_pkg::PROD_W'(R7)
  };

  localparam logic [tls_pkg::RECIP_W-1:0] RECIP =
    tls_pkg::RECIP_W'((64'd1 << tls_pkg::FOLD_K) / SETS);

  localparam logic [tls_pkg::Y_W-1:0] SETS_Y = tls_pkg::Y_W'(SETS);

  logic a_v_r, b_v_r, c_v_r, d_v_r, e_v_r;
  logic a_free, b_free, c_free, d_free, e_free;

  logic                      a_op_r, b_op_r, c_op_r, d_op_r, e_op_r;
  logic [tls_pkg::ADDR_W-1:0] a_addr_r, b_addr_r, c_addr_r, d_addr_r, e_addr_r;

  logic [tls_pkg::ADDR_W-1:0] page;
  logic [tls_pkg::PROD_W-1:0] prod_nxt [tls_pkg::DIGITS];
  logic [tls_pkg::PROD_W-1:0] prod_a_r [tls_pkg::DIGITS];
  logic [tls_pkg::Y_W-1:0]    y_nxt, y_b_r, y_c_r, y_d_r;
  logic [tls_pkg::MUL_W-1:0]  mul;
  logic [tls_pkg::Y_W-1:0]    q_nxt, q_c_r;
  logic [tls_pkg::Y_W-1:0]    qs_nxt, qs_d_r;
  logic [tls_pkg::Y_W-1:0]    rem, rem_fix;
  logic [SW-1:0]             set_nxt, e_set_r;

  assign e_free  = !e_v_r || down_free;
  assign d_free  = !d_v_r || e_free;
  assign c_free  = !c_v_r || d_free;
  assign b_free  = !b_v_r || c_free;
  assign a_free  = !a_v_r || b_free;
  assign up_free = a_free;

  // byte-wise products with constant residues
  assign page = in_addr >> PAGE_SHIFT;

  always_comb begin
    for (int i = 0; i < tls_pkg::DIGITS; i++) begin
      prod_nxt[i] = tls_pkg::PROD_W'(page[8*i +: 8]) * RES[i];
    end
  end

  always_comb begin
    y_nxt = '0;
    for (int i = 0; i < tls_pkg::DIGITS; i++) begin
      y_nxt = y_nxt + tls_pkg::Y_W'(prod_a_r[i]);
    end
  end

  // quotient estimate, low by at most one
  assign mul   = tls_pkg::MUL_W'(y_b_r) * tls_pkg::MUL_W'(RECIP);
  assign q_nxt = tls_pkg::Y_W'(mul >> tls_pkg::FOLD_K);

  // q * sets never exceeds the folded value
  assign qs_nxt = q_c_r * SETS_Y;

  assign rem     = y_d_r - qs_d_r;
  assign rem_fix = (rem >= SETS_Y) ? rem - SETS_Y : rem;
  assign set_nxt = SW'(rem_fix);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
    end else begin
      if (a_free) a_v_r <= in_take;
      if (b_free) b_v_r <= a_v_r;
      if (c_free) c_v_r <= b_v_r;
      if (d_free) d_v_r <= c_v_r;
      if (e_free) e_v_r <= d_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_op_r   <= in_op;
      a_addr_r <= in_addr;
      prod_a_r <= prod_nxt;
    end
    if (b_free && a_v_r) begin
      b_op_r   <= a_op_r;
      b_addr_r <= a_addr_r;
      y_b_r    <= y_nxt;
    end
    if (c_free && b_v_r) begin
      c_op_r   <= b_op_r;
      c_addr_r <= b_addr_r;
      y_c_r    <= y_b_r;
      q_c_r    <= q_nxt;
    end
    if (d_free && c_v_r) begin
      d_op_r   <= c_op_r;
      d_addr_r <= c_addr_r;
      y_d_r    <= y_c_r;
      qs_d_r   <= qs_nxt;
    end
    if (e_free && d_v_r) begin
      e_op_r   <= d_op_r;
      e_addr_r <= d_addr_r;
      e_set_r  <= set_nxt;
    end
  end

  assign e_valid = e_v_r;
  assign e_op    = e_op_r;
  assign e_addr  = e_addr_r;
  assign e_set   = e_set_r;

endmodule

// ===== sv/tls_tag_array.sv =====
module tls_tag_array #(
  parameter int SETS = 256,
  parameter int SW   = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       e_valid,
  input  logic                       e_op,
  input  logic [tls_pkg::ADDR_W-1:0] e_addr,
  input  logic [SW-1:0]              e_set,
  input  logic                       out_rdy,
  output tls_pkg::ta_ctl_t           ctl,
  output tls_pkg::res_t              res
);

  typedef enum logic [1:0] {
    CLR_SWEEP = 2'b01,
    CLR_DONE  = 2'b10
  } clr_state_t;

  clr_state_t state_r, state_nxt;
  logic [SW-1:0] clr_idx_r, clr_idx_nxt;

  tls_pkg::row_t mem [SETS];

  logic                       w_v_r;
  logic                       w_op_r;
  logic [tls_pkg::ADDR_W-1:0] w_addr_r;
  logic [SW-1:0]              w_set_r;
  logic                       fwd_r;
  tls_pkg::row_t              fwd_row_r;
  tls_pkg::row_t              rd_row_r;

  logic clearing, w_free, take_ok, e_adv, w_adv;

  tls_pkg::row_t cur, new_row;
  logic hit0, hit1, hit, hit_way, victim, way_sel, miss;
  logic [31:0] set_ext, slot_ext;

  logic          mem_we;
  logic [SW-1:0] mem_waddr;
  tls_pkg::row_t mem_wdata;

  // clear sweep over all sets after reset
  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    unique case (state_r)
      CLR_SWEEP: begin
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == SW'(SETS - 1)) state_nxt = CLR_DONE;
      end
      CLR_DONE: begin
        clr_idx_nxt = clr_idx_r;
      end
      default: begin
        state_nxt = CLR_SWEEP;
      end
    endcase
  end

  assign clearing = (state_r == CLR_SWEEP);
  assign w_free   = !w_v_r || out_rdy;
  assign take_ok  = w_free && !clearing;
  assign e_adv    = e_valid && take_ok;
  assign w_adv    = w_v_r && out_rdy;

  // set contents, with the row written last cycle taking precedence
  assign cur = fwd_r ? fwd_row_r : rd_row_r;

  assign hit0    = cur.valid0 && (cur.tag0 == w_addr_r);
  assign hit1    = cur.valid1 && (cur.tag1 == w_addr_r);
  assign hit     = hit0 || hit1;
  assign hit_way = !hit0;

  always_comb begin
    priority if (!cur.valid0) victim = 1'b0;
    else if (!cur.valid1)     victim = 1'b1;
    else                      victim = !cur.lru;
  end

  always_comb begin
    if (w_op_r == tls_pkg::OP_UPDATE) way_sel = hit ? hit_way : victim;
    else                              way_sel = hit_way;
  end

  assign miss = (w_op_r == tls_pkg::OP_LOOKUP) && !hit;

  always_comb begin
    new_row = cur;
    if (w_op_r == tls_pkg::OP_UPDATE) begin
      if (way_sel) begin
        new_row.tag1   = w_addr_r;
        new_row.valid1 = 1'b1;
      end else begin
        new_row.tag0   = w_addr_r;
        new_row.valid0 = 1'b1;
      end
    end
    // the way used becomes most recent, the other one least recent
    if (!miss) new_row.lru = way_sel;
  end

  assign set_ext  = 32'(w_set_r);
  assign slot_ext = {set_ext[30:0], way_sel};

  always_comb begin
    res.status     = miss ? tls_pkg::STATUS_MISS : tls_pkg::STATUS_OK;
    res.way_used   = miss ? 1'b0 : way_sel;
    res.set_number = set_ext[7:0];
    res.page_slot  = miss ? 9'd0 : slot_ext[8:0];
  end

  assign ctl.clearing  = clearing;
  assign ctl.res_valid = w_v_r;
  assign ctl.take_ok   = take_ok;

  assign mem_we    = clearing || w_adv;
  assign mem_waddr = clearing ? clr_idx_r : w_set_r;
  assign mem_wdata = clearing ? tls_pkg::row_t'('0) : new_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= CLR_SWEEP;
      clr_idx_r <= '0;
      w_v_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      if (w_free) w_v_r <= e_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (e_adv) begin
      w_op_r    <= e_op;
      w_addr_r  <= e_addr;
      w_set_r   <= e_set;
      fwd_r     <= w_adv && (w_set_r == e_set);
      fwd_row_r <= new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (e_adv)  rd_row_r <= mem[e_set];
  end

endmodule

// ===== sv/two_way_lru_tag_store.sv =====
// channel   dir  handshake          word fields
// in_       in   in_valid/in_stall   in_operation, in_page_address
// out_      out  out_valid/out_stall out_status, out_way_used, out_set_number,
//                                   out_page_slot
//
// one word accepted per cycle while in_stall is low
// each word passes the set index fold (five stages), the tag compare stage and
// the output register
// after reset the tag array is swept one set per cycle, over all SETS sets,
// with in_stall high throughout
// reset is synchronous, active low
// out_stall holds the output register, words keep entering until every
// pipeline stage is full
module two_way_lru_tag_store #(
  parameter int SETS       = 256,
  parameter int PAGE_SHIFT = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [63:0] in_page_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_status,
  output logic        out_way_used,
  output logic [7:0]  out_set_number,
  output logic [8:0]  out_page_slot
);

  // set index width, at least one bit
  localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;

  logic in_take;
  logic up_free;
  logic out_rdy;

  logic                       e_valid;
  logic                       e_op;
  logic [tls_pkg::ADDR_W-1:0] e_addr;
  logic [SW-1:0]              e_set;

  tls_pkg::ta_ctl_t ctl;
  tls_pkg::res_t    res;

  // output register
  logic          out_valid_r;
  tls_pkg::res_t out_res_r;

  // output register frees when empty or being taken
  assign out_rdy = !out_valid_r || !out_stall;

  // no words while the clear sweep runs
  assign in_stall = !up_free || ctl.clearing;
  assign in_take  = in_valid && !in_stall;

  // page number modulo the set count, folded over five stages
  tls_set_index #(
    .SETS       (SETS),
    .PAGE_SHIFT (PAGE_SHIFT),
    .SW         (SW)
  ) u_set_index (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_take   (in_take),
    .in_op     (in_operation),
    .in_addr   (in_page_address),
    .down_free (ctl.take_ok),
    .up_free   (up_free),
    .e_valid   (e_valid),
    .e_op      (e_op),
    .e_addr    (e_addr),
    .e_set     (e_set)
  );

  // set memory, two-way compare, replacement choice and write-back
  tls_tag_array #(
    .SETS (SETS),
    .SW   (SW)
  ) u_tag_array (
    .clk     (clk),
    .rst_n   (rst_n),
    .e_valid (e_valid),
    .e_op    (e_op),
    .e_addr  (e_addr),
    .e_set   (e_set),
    .out_rdy (out_rdy),
    .ctl     (ctl),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= ctl.res_valid;
    end
  end

  // payload holds while stalled
  always_ff @(posedge clk) begin
    if (out_rdy && ctl.res_valid) out_res_r <= res;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_res_r.status;
  assign out_way_used   = out_res_r.way_used;
  assign out_set_number = out_res_r.set_number;
  assign out_page_slot  = out_res_r.page_slot;

endmodule

// ===== sv/tls_checker.sv =====
`include "two_way_lru_tag_store_defines.svh"

module tls_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_status,
  input logic       out_way_used,
  input logic [7:0] out_set_number,
  input logic [8:0] out_page_slot
);

  // a stalled result word holds
  `TLS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_way_used) && $stable(out_set_number) && $stable(out_page_slot), "stalled result word changed")

  // a miss carries way 0 and slot 0
  `TLS_ASSERT_NOW(a_miss_zero, out_valid && (out_status == tls_pkg::STATUS_MISS), (out_way_used == 1'b0) && (out_page_slot == 9'd0), "miss with nonzero way or slot")

  // on success the slot is set times two plus way
  `TLS_ASSERT_NOW(a_slot_form, out_valid && (out_status == tls_pkg::STATUS_OK), (out_page_slot[0] == out_way_used) && (out_page_slot[8:1] == out_set_number[7:0]), "slot does not match set and way")

  // reset empties the output and starts the clear sweep
  `TLS_ASSERT_AFTER_RST(a_rst_state, !out_valid && in_stall, "output valid or input open after reset")

endmodule

bind two_way_lru_tag_store tls_checker u_tls_checker (.*);

// ===== sim/two_way_lru_tag_store_tb.sv =====
`timescale 1ns / 100ps

module two_way_lru_tag_store_tb;

  localparam int SETS         = 256;
  localparam int PAGE_SHIFT   = 12;
  localparam int ENTRIES      = 2 * SETS;
  // slack for a word to pass through the block, rounded up generously
  localparam int DRAIN_CYCLES = 20;
  localparam int LONG_HOLD    = 200;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_WORDS = 850;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_operation;
  logic [63:0] in_page_address;
  logic        out_valid;
  logic        out_stall;
  logic        out_status;
  logic        out_way_used;
  logic [7:0]  out_set_number;
  logic [8:0]  out_page_slot;

  two_way_lru_tag_store #(
    .SETS       (SETS),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_page_address (in_page_address),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_way_used    (out_way_used),
    .out_set_number  (out_set_number),
    .out_page_slot   (out_page_slot)
  );

  // shadow copy of the tag store, entry index is set * 2 + way
  bit [63:0] shadow_tag [ENTRIES];
  bit        shadow_valid [ENTRIES];
  // set means that way is the least recent one of its set
  bit        shadow_stale [ENTRIES];

  tls_pkg::res_t pending_results [$];
  int unsigned   mismatch_count;
  int unsigned   cycle_count;

  // calm turns off idling on both sides for a stretch
  bit          calm;
  // asks the receiver process for one long hold-off
  bit          hold_req;
  int          hold_count;

  // address pools keep the working set small so sets fill and evict
  bit [43:0]   upper_pool [6];
  bit [11:0]   offset_pool [3];

  // clock, 10 ns period
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit, no correct run comes near it
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run limit of %0d cycles reached", $realtime, CYCLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // expected result of one lookup or update, advances the shadow state
  function automatic tls_pkg::res_t predict_tag_access(logic op, logic [63:0] addr);
    int            set_idx;
    int            base;
    logic          way;
    bit            hit;
    tls_pkg::res_t r;
    set_idx = int'((addr >> PAGE_SHIFT) % SETS);
    base    = set_idx * 2;
    hit     = 1'b0;
    way     = 1'b0;
    // way 0 wins when both ways would match
    if (shadow_valid[base] && shadow_tag[base] == addr) begin
      hit = 1'b1;
      way = 1'b0;
    end else if (shadow_valid[base + 1] && shadow_tag[base + 1] == addr) begin
      hit = 1'b1;
      way = 1'b1;
    end
    r.status     = tls_pkg::STATUS_OK;
    r.set_number = set_idx[7:0];
    if (op == tls_pkg::OP_LOOKUP && !hit) begin
      // miss leaves the store alone, way and slot read as zero
      r.status    = tls_pkg::STATUS_MISS;
      r.way_used  = 1'b0;
      r.page_slot = '0;
      return r;
    end
    if (op == tls_pkg::OP_UPDATE && !hit) begin
      // first invalid way, else the least recent one
      if (!shadow_valid[base])
        way = 1'b0;
      else if (!shadow_valid[base + 1])
        way = 1'b1;
      else
        way = shadow_stale[base] ? 1'b0 : 1'b1;
    end
    if (op == tls_pkg::OP_UPDATE) begin
      shadow_tag[base + way]   = addr;
      shadow_valid[base + way] = 1'b1;
    end
    shadow_stale[base + way]         = 1'b0;
    shadow_stale[base + (way ^ 1'b1)] = 1'b1;
    r.way_used  = way;
    r.page_slot = 9'(base + way);
    return r;
  endfunction

  // input monitor: every accepted word gets its expectation
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      pending_results.push_back(predict_tag_access(in_operation, in_page_address));
  end

  task automatic compare_field(string name, logic [8:0] want, logic [8:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $realtime, name, want, got);
      mismatch_count++;
    end
  endtask

  // result checker, oldest expectation first
  always @(posedge clk) begin
    tls_pkg::res_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word with nothing expected, actual %b %b %h %h", $realtime,
                 out_status, out_way_used, out_set_number, out_page_slot);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("status", 9'(want.status), 9'(out_status));
        compare_field("way_used", 9'(want.way_used), 9'(out_way_used));
        compare_field("set_number", 9'(want.set_number), 9'(out_set_number));
        compare_field("page_slot", want.page_slot, out_page_slot);
      end
    end
  end

  // receiver: mostly ready, short stalls, now and then a long one
  initial begin
    int r;
    int n;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        // long hold-off so the pipeline fills and stalls the input
        out_stall <= 1'b1;
        hold_count = 0;
        while (hold_count < LONG_HOLD) begin
          @(posedge clk);
          hold_count++;
        end
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_stall <= 1'b0;
        end else begin
          n = (r < 96) ? $urandom_range(1, 3) : $urandom_range(10, 40);
          out_stall <= 1'b1;
          repeat (n - 1) @(posedge clk);
        end
      end
    end
  end

  // sender gap after a word, zero while calm
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // lookup or update at random
  function automatic logic pick_op();
    return $urandom_range(0, 1) ? tls_pkg::OP_UPDATE : tls_pkg::OP_LOOKUP;
  endfunction

  // address drawn mostly from a few sets and tags, sometimes fully random
  function automatic logic [63:0] pick_address();
    logic [63:0] a;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 10)
      return {$urandom, $urandom};
    a = 64'(upper_pool[$urandom_range(0, 5)]) << (PAGE_SHIFT + 8);
    if (r < 80)
      a = a | (64'($urandom_range(0, 3)) << PAGE_SHIFT);
    else
      a = a | (64'($urandom_range(0, SETS - 1)) << PAGE_SHIFT);
    return a | 64'(offset_pool[$urandom_range(0, 2)]);
  endfunction

  // offer one word and hold it until accepted, then idle for a random gap, which may be zero
  task automatic send_word(logic op, logic [63:0] addr);
    int gap;
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_page_address <= addr;
    do @(posedge clk); while (in_stall !== 1'b0);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // one edge first so the last accepted word is already queued
  task automatic wait_drain();
    @(posedge clk);
    while (pending_results.size() != 0)
      @(posedge clk);
  endtask

  // zero address and all-ones address at both ends of the set range
  task automatic test_address_extremes();
    send_word(tls_pkg::OP_LOOKUP, 64'h0);         // empty store, zero tag is no hit
    send_word(tls_pkg::OP_UPDATE, 64'h0);
    send_word(tls_pkg::OP_LOOKUP, 64'h0);
    send_word(tls_pkg::OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(tls_pkg::OP_UPDATE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(tls_pkg::OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(tls_pkg::OP_UPDATE, 64'hFFFF_FFFF_FFFF_FFFF); // update that hits
    send_word(tls_pkg::OP_LOOKUP, 64'h0);
  endtask

  // fill one set, then walk the replacement order through it
  task automatic test_replacement();
    send_word(tls_pkg::OP_UPDATE, 64'h0000_0001_0000_5000); // A into way 0
    send_word(tls_pkg::OP_UPDATE, 64'h0000_0002_0000_5000); // B into way 1
    send_word(tls_pkg::OP_LOOKUP, 64'h0000_0001_0000_5000); // A hit, way 1 least recent
    send_word(tls_pkg::OP_UPDATE, 64'h0000_0003_0000_5123); // C evicts B
    send_word(tls_pkg::OP_LOOKUP, 64'h0000_0002_0000_5000); // B gone
    send_word(tls_pkg::OP_LOOKUP, 64'h0000_0003_0000_5123); // C hit, way 0 least recent
    send_word(tls_pkg::OP_UPDATE, 64'hA000_0000_0000_5FFF); // D evicts A
    send_word(tls_pkg::OP_LOOKUP, 64'h0000_0001_0000_5000);
    send_word(tls_pkg::OP_UPDATE, 64'hA000_0000_0000_5FFF); // D again, hits in place
    send_word(tls_pkg::OP_UPDATE, 64'h0000_0002_0000_5000); // B evicts C
    send_word(tls_pkg::OP_LOOKUP, 64'h0000_0003_0000_5123);
    send_word(tls_pkg::OP_LOOKUP, 64'h0000_0002_0000_5001); // same page, other offset: miss
    send_word(tls_pkg::OP_LOOKUP, 64'hA000_0000_0000_5FFF);
  endtask

  // receiver holds off while the sender keeps offering words
  task automatic test_output_backpressure();
    hold_req = 1'b1;
    while (!out_stall) @(posedge clk);
    calm = 1'b1;
    repeat (40) send_word(pick_op(), pick_address());
    calm = 1'b0;
  endtask

  // sender stops until every result is back, then resumes
  task automatic test_drain_pause();
    repeat (12) send_word(pick_op(), pick_address());
    in_valid <= 1'b0;
    wait_drain();
    repeat (8) send_word(pick_op(), pick_address());
  endtask

  // bulk random traffic, every fifth chunk without idling
  task automatic test_random_traffic();
    for (int chunk = 0; chunk < RANDOM_WORDS / 50; chunk++) begin
      calm = (chunk % 5 == 2);
      repeat (50) send_word(pick_op(), pick_address());
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_operation    = tls_pkg::OP_LOOKUP;
    in_page_address = '0;
    mismatch_count  = 0;
    cycle_count     = 0;
    calm            = 1'b0;
    hold_req        = 1'b0;
    upper_pool[0]   = '0;
    upper_pool[1]   = '1;
    for (int i = 2; i < 6; i++)
      upper_pool[i] = {$urandom, $urandom};
    offset_pool[0]  = '0;
    offset_pool[1]  = '1;
    offset_pool[2]  = 12'($urandom);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // the clearing sweep after reset shows up as in_stall, send_word waits it out
    test_address_extremes();
    test_replacement();
    test_output_backpressure();
    test_drain_pause();
    test_random_traffic();
    in_valid <= 1'b0;

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
